// ----- design/oriented_box_overlap_test_2d_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ORIENTED_BOX_OVERLAP_TEST_2D_MACROS_SVH
`define ORIENTED_BOX_OVERLAP_TEST_2D_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define OBBSAT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("obbsat assertion failed");

// Next-cycle implication, checked outside reset.
`define OBBSAT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("obbsat assertion failed");

`else

`define OBBSAT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define OBBSAT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// ----- design/obbsat_pkg.sv -----
package obbsat_pkg;

  // Field widths
  localparam int POS_W  = 24;  // Q15.8 center coordinate
  localparam int EXT_W  = 23;  // Q15.8 half extent
  localparam int AXC_W  = 16;  // Q1.14 axis component

  // Internal widths
  localparam int DIFF_W      = POS_W + 1;        // center difference
  localparam int UVEC_W      = AXC_W + 1;        // axis component, negation safe
  localparam int ADOT_PROD_W = 2 * AXC_W;        // axis component product
  localparam int KDOT_W      = ADOT_PROD_W + 1;  // axis dot axis, and its magnitude
  localparam int CPROD_W     = DIFF_W + UVEC_W;  // center times axis component
  localparam int CSUM_W      = CPROD_W + 1;      // center projection
  localparam int RPROD_W     = KDOT_W + EXT_W;   // projected radius term
  localparam int CMP_W       = 58;               // common 36 fraction bit scale

  localparam int CP_SHIFT  = 14;  // Q.22 -> Q.36
  localparam int OWN_SHIFT = 28;  // Q.8  -> Q.36

  // Separating axis codes
  localparam logic [2:0] AXIS_NONE = 3'd0;
  localparam logic [2:0] AXIS_AX   = 3'd1;
  localparam logic [2:0] AXIS_AY   = 3'd2;
  localparam logic [2:0] AXIS_BX   = 3'd3;
  localparam logic [2:0] AXIS_BY   = 3'd4;

  // Operands of one candidate axis, as they leave the first stage
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;   // center difference A - B
    logic signed [DIFF_W-1:0] dy;
    logic signed [UVEC_W-1:0] ux;   // axis under test
    logic signed [UVEC_W-1:0] uy;
    logic [EXT_W-1:0]         own;  // extent of the box owning the axis
    logic [EXT_W-1:0]         ow;   // other box, along its x axis
    logic [EXT_W-1:0]         oh;   // other box, along its y axis
  } obbsat_lane_t;

endpackage

// ----- design/obbsat_axis.sv -----
module obbsat_axis (
  input  logic                               clk,
  input  obbsat_pkg::obbsat_lane_t           lane,
  input  logic [obbsat_pkg::KDOT_W-1:0]      kw,
  input  logic [obbsat_pkg::KDOT_W-1:0]      kh,
  output logic                               sep
);
  import obbsat_pkg::*;

  logic signed [CPROD_W-1:0] pux;
  logic signed [CPROD_W-1:0] puy;
  logic [EXT_W-1:0]          own2;
  logic [EXT_W-1:0]          ow2;
  logic [EXT_W-1:0]          oh2;
  logic signed [CSUM_W-1:0]  csum;
  logic [CSUM_W-1:0]         cabs;
  logic [RPROD_W-1:0]        rw;
  logic [RPROD_W-1:0]        rh;
  logic [EXT_W-1:0]          own3;
  logic [CMP_W-1:0]          cp;
  logic [CMP_W-1:0]          rad;

  // Stage 2: center products, extents follow
  always_ff @(posedge clk) begin
    pux  <= lane.dx * lane.ux;
    puy  <= lane.dy * lane.uy;
    own2 <= lane.own;
    ow2  <= lane.ow;
    oh2  <= lane.oh;
  end

  assign csum = CSUM_W'(pux) + CSUM_W'(puy);

  // Stage 3: center projection magnitude, projected radius terms
  always_ff @(posedge clk) begin
    cabs <= csum[CSUM_W-1] ? CSUM_W'(-csum) : CSUM_W'(csum);
    rw   <= RPROD_W'(kw) * RPROD_W'(ow2);
    rh   <= RPROD_W'(kh) * RPROD_W'(oh2);
    own3 <= own2;
  end

  // Stage 4: both sides in the common scale
  always_ff @(posedge clk) begin
    cp  <= CMP_W'(cabs) << CP_SHIFT;
    rad <= (CMP_W'(own3) << OWN_SHIFT) + CMP_W'(rw) + CMP_W'(rh);
  end

  // Stage 5: strict compare, touching boxes do not separate
  always_ff @(posedge clk) begin
    sep <= cp > rad;
  end

endmodule

// ----- design/oriented_box_overlap_test_2d.sv -----
// Separating-axis overlap test for two oriented rectangles. A request is taken
// on every cycle that start is high (busy stays low). Its result is driven on
// overlap and separating_axis with done high for one cycle; one result per
// cycle is sustained. The pipeline has six stages: axis products, axis dot
// magnitudes and center products, the radius multipliers, the sums, the
// compare, and the output register. Results cannot be held off, so none is
// ever queued.
`include "oriented_box_overlap_test_2d_macros.svh"

module oriented_box_overlap_test_2d (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [obbsat_pkg::POS_W-1:0]    a_center_x,
  input  logic signed [obbsat_pkg::POS_W-1:0]    a_center_y,
  input  logic signed [obbsat_pkg::AXC_W-1:0]    a_axis_cos,
  input  logic signed [obbsat_pkg::AXC_W-1:0]    a_axis_sin,
  input  logic        [obbsat_pkg::EXT_W-1:0]    a_half_width,
  input  logic        [obbsat_pkg::EXT_W-1:0]    a_half_height,
  input  logic signed [obbsat_pkg::POS_W-1:0]    b_center_x,
  input  logic signed [obbsat_pkg::POS_W-1:0]    b_center_y,
  input  logic signed [obbsat_pkg::AXC_W-1:0]    b_axis_cos,
  input  logic signed [obbsat_pkg::AXC_W-1:0]    b_axis_sin,
  input  logic        [obbsat_pkg::EXT_W-1:0]    b_half_width,
  input  logic        [obbsat_pkg::EXT_W-1:0]    b_half_height,
  output logic                                   done,
  output logic                                   overlap,
  output logic [2:0]                             separating_axis
);
  import obbsat_pkg::*;

  localparam int LATENCY = 6;

  logic                          accept;
  logic [4:0]                    vld;        // valid of stages 1..5
  logic signed [DIFF_W-1:0]      dx;
  logic signed [DIFF_W-1:0]      dy;
  logic signed [UVEC_W-1:0]      a_ux;
  logic signed [UVEC_W-1:0]      a_uy;
  logic signed [UVEC_W-1:0]      a_vx;
  logic signed [UVEC_W-1:0]      a_vy;
  logic signed [UVEC_W-1:0]      b_ux;
  logic signed [UVEC_W-1:0]      b_uy;
  logic signed [UVEC_W-1:0]      b_vx;
  logic signed [UVEC_W-1:0]      b_vy;
  logic [EXT_W-1:0]              aw;
  logic [EXT_W-1:0]              ah;
  logic [EXT_W-1:0]              bw;
  logic [EXT_W-1:0]              bh;
  logic signed [ADOT_PROD_W-1:0] prod_cc;
  logic signed [ADOT_PROD_W-1:0] prod_ss;
  logic signed [ADOT_PROD_W-1:0] prod_sc;
  logic signed [ADOT_PROD_W-1:0] prod_cs;
  logic signed [KDOT_W-1:0]      c1;
  logic signed [KDOT_W-1:0]      c2;
  logic [KDOT_W-1:0]             k1;
  logic [KDOT_W-1:0]             k2;
  obbsat_lane_t                  lane_ax;
  obbsat_lane_t                  lane_ay;
  obbsat_lane_t                  lane_bx;
  obbsat_lane_t                  lane_by;
  logic [3:0]                    sep;
  logic                          overlap_next;
  logic [2:0]                    axis_next;

  // Never stalls: one request per cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[3:0], accept};
      done <= vld[4];
    end
  end

  // Stage 1: center difference, axis vectors, axis component products
  always_ff @(posedge clk) begin
    dx      <= DIFF_W'(a_center_x) - DIFF_W'(b_center_x);
    dy      <= DIFF_W'(a_center_y) - DIFF_W'(b_center_y);
    a_ux    <= UVEC_W'(a_axis_cos);
    a_uy    <= UVEC_W'(a_axis_sin);
    a_vx    <= -UVEC_W'(a_axis_sin);
    a_vy    <= UVEC_W'(a_axis_cos);
    b_ux    <= UVEC_W'(b_axis_cos);
    b_uy    <= UVEC_W'(b_axis_sin);
    b_vx    <= -UVEC_W'(b_axis_sin);
    b_vy    <= UVEC_W'(b_axis_cos);
    aw      <= a_half_width;
    ah      <= a_half_height;
    bw      <= b_half_width;
    bh      <= b_half_height;
    prod_cc <= a_axis_cos * b_axis_cos;
    prod_ss <= a_axis_sin * b_axis_sin;
    prod_sc <= a_axis_sin * b_axis_cos;
    prod_cs <= a_axis_cos * b_axis_sin;
  end

  // Axis-to-axis dots: |Ax.Bx| = |Ay.By| = |c1|, the cross pairs give |c2|
  assign c1 = KDOT_W'(prod_cc) + KDOT_W'(prod_ss);
  assign c2 = KDOT_W'(prod_sc) - KDOT_W'(prod_cs);

  // Stage 2: dot magnitudes, lined up with the lanes' center products
  always_ff @(posedge clk) begin
    k1 <= c1[KDOT_W-1] ? KDOT_W'(-c1) : KDOT_W'(c1);
    k2 <= c2[KDOT_W-1] ? KDOT_W'(-c2) : KDOT_W'(c2);
  end

  // Lane operands
  always_comb begin
    lane_ax = '{dx: dx, dy: dy, ux: a_ux, uy: a_uy, own: aw, ow: bw, oh: bh};
    lane_ay = '{dx: dx, dy: dy, ux: a_vx, uy: a_vy, own: ah, ow: bw, oh: bh};
    lane_bx = '{dx: dx, dy: dy, ux: b_ux, uy: b_uy, own: bw, ow: aw, oh: ah};
    lane_by = '{dx: dx, dy: dy, ux: b_vx, uy: b_vy, own: bh, ow: aw, oh: ah};
  end

  obbsat_axis u_axis_ax (.clk(clk), .lane(lane_ax), .kw(k1), .kh(k2), .sep(sep[0]));
  obbsat_axis u_axis_ay (.clk(clk), .lane(lane_ay), .kw(k2), .kh(k1), .sep(sep[1]));
  obbsat_axis u_axis_bx (.clk(clk), .lane(lane_bx), .kw(k1), .kh(k2), .sep(sep[2]));
  obbsat_axis u_axis_by (.clk(clk), .lane(lane_by), .kw(k2), .kh(k1), .sep(sep[3]));

  // First separating axis in test order
  always_comb begin
    overlap_next = 1'b0;
    priority if (sep[0]) axis_next = AXIS_AX;
    else if (sep[1])     axis_next = AXIS_AY;
    else if (sep[2])     axis_next = AXIS_BX;
    else if (sep[3])     axis_next = AXIS_BY;
    else begin
      axis_next    = AXIS_NONE;
      overlap_next = 1'b1;
    end
  end

  // Stage 6: result register
  always_ff @(posedge clk) begin
    overlap         <= overlap_next;
    separating_axis <= axis_next;
  end

  // Every result traces back to an earlier request
  `OBBSAT_ASSERT_IMP(a_done_from_request, clk, rst, done, $past(start, LATENCY))
  // Flag and axis code agree
  `OBBSAT_ASSERT_IMP(a_flag_matches_axis, clk, rst, done,
                     overlap == (separating_axis == AXIS_NONE))
  // No lane separating means an overlap is reported
  `OBBSAT_ASSERT_NXT(a_clear_lanes_overlap, clk, rst, vld[4] && (sep == 4'b0000),
                     done && overlap)

endmodule
